// ===== design/pgi_pkg.sv =====
// Package for the pairwise gravity impulse pipeline.
// Holds the field widths, stage depths, register codes and the shared types.
// No dependencies.
`default_nettype none
package pgi_pkg;

   localparam int unsigned WORD_W   = 32;   // one input or output field
   localparam int unsigned R2_W     = 66;   // exact squared distance, Q34.32
   localparam int unsigned NUM_W    = 104;  // G*mA*mB*dt with the 2^24 already removed
   localparam int unsigned JMAG_W   = 65;   // impulse magnitude, clamped below 2^65
   localparam int unsigned ROOT_W   = 33;   // floor(sqrt(r2))
   localparam int unsigned PROD_W   = 97;   // JMAG_W + WORD_W
   localparam int unsigned FRONT_LAT = 4;
   localparam int unsigned AXIS_LAT  = 3 + WORD_W;
   localparam int unsigned PIPE_LAT  = FRONT_LAT + JMAG_W + AXIS_LAT + 1;

   typedef enum logic [1:0] {
      CSR_G_CONSTANT    = 2'd0,
      CSR_TIME_STEP     = 2'd1,
      CSR_MIN_R_SQUARED = 2'd2
   } csr_index_type;

   // sign and magnitude of one separation component
   typedef struct packed {
      logic              neg;
      logic [WORD_W-1:0] mag;
   } axis_type;

   // what the front end hands to the divider, the square root and the side delay
   typedef struct packed {
      logic [R2_W-1:0]          den;
      logic [R2_W-1:0]          num_hi;
      logic [JMAG_W-1:0]        num_lo;
      logic [R2_W-1:0]          r2;
      logic                     ovf;
      axis_type [2:0]           axis;
   } front_type;

endpackage
`default_nettype wire

// ===== design/pgi_delay.sv =====
// Enabled shift line that holds side data level with a pipelined unit.
// Depends on nothing.
`default_nettype none
module pgi_delay #(
   parameter int unsigned W = 8,
   parameter int unsigned D = 4
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] line_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int k = 1; k < D; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign dout = line_ff[D-1];
endmodule
`default_nettype wire

// ===== design/pgi_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Numerator is {num_hi, num_lo} with num_hi below den. Depends on nothing.
`default_nettype none
module pgi_udiv #(
   parameter int unsigned QW = 32,
   parameter int unsigned DW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] num_hi,
   input  logic [QW-1:0] num_lo,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [DW-1:0] den_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] lo_prev;
      logic [DW-1:0] den_prev;
      logic [DW:0]   cat;
      logic [DW:0]   diff;
      logic          fits;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num_hi;
         assign lo_prev  = num_lo;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign cat    = {rem_prev, lo_prev[QW-1]};
      assign diff   = cat - {1'b0, den_prev};
      assign fits   = ~diff[DW];
      assign rem_in = fits ? diff[DW-1:0] : cat[DW-1:0];
      assign lo_in  = {lo_prev[QW-2:0], fits};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= lo_in;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = lo_ff[QW-1];
endmodule
`default_nettype wire

// ===== design/pgi_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives floor(sqrt(rad)). Depends on nothing.
`default_nettype none
module pgi_isqrt #(
   parameter int unsigned RW = 16
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] rad,
   output logic [RW-1:0]   root
);
   logic [2*RW-1:0] rad_ff  [RW];
   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [2*RW-1:0] rad_prev;
      logic [RW:0]     rem_prev;
      logic [RW-1:0]   root_prev;
      logic [RW+2:0]   cat;
      logic [RW+2:0]   trial;
      logic [RW+2:0]   diff;
      logic            fits;

      if (k == 0) begin : g_first
         assign rad_prev  = rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // bring down the next bit pair, try root*4+1
      assign cat   = {rem_prev, rad_prev[2*RW-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign diff  = cat - trial;
      assign fits  = ~diff[RW+2];

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_prev[2*RW-3:0], 2'b00};
            rem_ff[k]  <= fits ? diff[RW:0] : cat[RW:0];
            root_ff[k] <= {root_prev[RW-2:0], fits};
         end
      end
   end

   assign root = root_ff[RW-1];
endmodule
`default_nettype wire

// ===== design/pgi_front.sv =====
// Front end: separation, squared distance, mass and constant products, floor.
// Four register stages. Depends on pgi_pkg.
`default_nettype none
module pgi_front (
   input  logic                            clock,
   input  logic                            en,
   input  logic [2:0][pgi_pkg::WORD_W-1:0] pos_a,
   input  logic [2:0][pgi_pkg::WORD_W-1:0] pos_b,
   input  logic [pgi_pkg::WORD_W-1:0]      mass_a,
   input  logic [pgi_pkg::WORD_W-1:0]      mass_b,
   input  logic [pgi_pkg::WORD_W-1:0]      g_constant,
   input  logic [pgi_pkg::WORD_W-1:0]      time_step,
   input  logic [pgi_pkg::WORD_W-1:0]      min_r_squared,
   output pgi_pkg::front_type              front
);
   import pgi_pkg::*;

   // stage 1
   axis_type [2:0] axis1_in, axis1_ff;
   logic [63:0]    mm1_in, mm1_ff, gt1_in, gt1_ff;
   logic [32:0]    diff [3];
   // stage 2
   axis_type [2:0] axis2_ff;
   logic [63:0]    sq2_ff [3];
   logic [63:0]    pll2_ff, plh2_ff, phl2_ff, phh2_ff;
   // stage 3
   axis_type [2:0]   axis3_ff;
   logic [R2_W-1:0]  r2_3_in, r2_3_ff;
   logic [127:0]     num3_in;
   logic [NUM_W-1:0] num3_ff;
   // stage 4
   logic [R2_W-1:0]  floor_ext, den4_in;
   front_type        front_in, front_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {pos_b[i][WORD_W-1], pos_b[i]} - {pos_a[i][WORD_W-1], pos_a[i]};
         axis1_in[i].neg = diff[i][32];
         axis1_in[i].mag = diff[i][32] ? 32'(~diff[i] + 33'd1) : diff[i][31:0];
      end
   end

   assign mm1_in = mass_a * mass_b;
   assign gt1_in = g_constant * time_step;

   assign r2_3_in = R2_W'(sq2_ff[0]) + R2_W'(sq2_ff[1]) + R2_W'(sq2_ff[2]);
   assign num3_in = {phh2_ff, 64'd0} + {32'd0, plh2_ff, 32'd0}
                  + {32'd0, phl2_ff, 32'd0} + {64'd0, pll2_ff};

   // raise the squared distance to the softening floor
   assign floor_ext = {34'd0, min_r_squared};
   assign den4_in   = (r2_3_ff < floor_ext) ? floor_ext : r2_3_ff;

   always_comb begin
      front_in.den    = den4_in;
      front_in.num_hi = {27'd0, num3_ff[NUM_W-1:JMAG_W]};
      front_in.num_lo = num3_ff[JMAG_W-1:0];
      front_in.r2     = r2_3_ff;
      front_in.ovf    = {27'd0, num3_ff[NUM_W-1:JMAG_W]} >= den4_in;
      front_in.axis   = axis3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axis1_ff <= axis1_in;
         mm1_ff   <= mm1_in;
         gt1_ff   <= gt1_in;

         axis2_ff <= axis1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= axis1_ff[i].mag * axis1_ff[i].mag;
         end
         pll2_ff <= mm1_ff[31:0]  * gt1_ff[31:0];
         plh2_ff <= mm1_ff[31:0]  * gt1_ff[63:32];
         phl2_ff <= mm1_ff[63:32] * gt1_ff[31:0];
         phh2_ff <= mm1_ff[63:32] * gt1_ff[63:32];

         axis3_ff <= axis2_ff;
         r2_3_ff  <= r2_3_in;
         num3_ff  <= num3_in[127:24];

         front_ff <= front_in;
      end
   end

   assign front = front_ff;
endmodule
`default_nettype wire

// ===== design/pgi_axis.sv =====
// One output component: magnitude*|d|/r with clip, sign and saturation flag.
// Three product stages then a 32-stage divider. Depends on pgi_pkg, pgi_udiv, pgi_delay.
`default_nettype none
module pgi_axis (
   input  logic                       clock,
   input  logic                       en,
   input  logic [pgi_pkg::JMAG_W-1:0] jmag,
   input  logic [pgi_pkg::ROOT_W-1:0] root,
   input  pgi_pkg::axis_type          axis,
   output logic [pgi_pkg::WORD_W-1:0] impulse,
   output logic                       sat
);
   import pgi_pkg::*;

   logic [63:0]        p0_ff, p1_ff;
   logic [WORD_W-1:0]  p2_ff;
   logic [ROOT_W-1:0]  r1_ff, r2_ff, r3_ff;
   logic [1:0]         fl1_ff, fl2_ff;
   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic [ROOT_W-1:0]  hi3_ff;
   logic [WORD_W-1:0]  lo3_ff;
   logic [2:0]         fl3_ff, fl_out;
   logic [WORD_W-1:0]  quo, lim, val;
   logic               clip;

   assign prod_in = {p2_ff, 64'd0} + {1'b0, p1_ff, 32'd0} + {33'd0, p0_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= jmag[31:0]  * axis.mag;
         p1_ff  <= jmag[63:32] * axis.mag;
         p2_ff  <= jmag[64] ? axis.mag : '0;
         r1_ff  <= root;
         fl1_ff <= {axis.mag != '0, axis.neg};

         prod_ff <= prod_in;
         r2_ff   <= r1_ff;
         fl2_ff  <= fl1_ff;

         hi3_ff <= prod_ff[64:32];
         lo3_ff <= prod_ff[31:0];
         r3_ff  <= r2_ff;
         fl3_ff <= {prod_ff[PROD_W-1:32] >= {32'd0, r2_ff}, fl2_ff};
      end
   end

   pgi_udiv #(.QW(WORD_W), .DW(ROOT_W)) u_div (
      .clock  (clock),
      .en     (en),
      .num_hi (hi3_ff),
      .num_lo (lo3_ff),
      .den    (r3_ff),
      .quo    (quo)
   );

   pgi_delay #(.W(3), .D(WORD_W)) u_flags (
      .clock (clock),
      .en    (en),
      .din   (fl3_ff),
      .dout  (fl_out)
   );

   // fl_out: [2] quotient overflow, [1] nonzero component, [0] negative
   assign lim     = fl_out[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign clip    = fl_out[1] & (fl_out[2] | (quo > lim));
   assign val     = !fl_out[1] ? '0 : (clip ? lim : quo);
   assign impulse = fl_out[0] ? (~val + 32'd1) : val;
   assign sat     = clip;
endmodule
`default_nettype wire

// ===== design/pairwise_gravity_impulse.sv =====
// Pairwise gravity impulse: impulse on body A from body B, Q16.16.
// Path: front end, 65-stage magnitude divider, axis units, output register.
// Throughput: one transfer per cycle while the output is not stalled.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, high) clears all valid bits and loads the register defaults.
// Depends on pgi_pkg, pgi_front, pgi_udiv, pgi_isqrt, pgi_delay, pgi_axis.
`default_nettype none
module pairwise_gravity_impulse (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // impulse_x, impulse_y, impulse_z
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import pgi_pkg::*;

   logic [WORD_W-1:0]  g_ff, dt_ff, minr2_ff;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic               en;

   logic [2:0][WORD_W-1:0] pos_a, pos_b;
   front_type          front;
   logic [JMAG_W-1:0]  quo1, jmag;
   logic [ROOT_W-1:0]  root_early, root;
   axis_type [2:0]     axis_d;
   logic               ovf_d;
   logic [2:0][WORD_W-1:0] imp;
   logic [2:0]         sat;
   logic [95:0]        tdata_ff;
   logic               tuser_ff;

   // Advance everything whenever the output register is free or being drained.
   assign en         = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;

   // Valid bits travel with the data, one per register stage.
   assign vld_in = {vld_ff[PIPE_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Configuration registers; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff     <= 32'd16777216;
         dt_ff    <= 32'd655;
         minr2_ff <= 32'd42950;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_G_CONSTANT:    g_ff     <= csr_wdata;
            CSR_TIME_STEP:     dt_ff    <= csr_wdata;
            CSR_MIN_R_SQUARED: minr2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the request transfer.
   for (genvar i = 0; i < 3; i++) begin : g_pos
      assign pos_a[i] = req_tdata[WORD_W*i +: WORD_W];
      assign pos_b[i] = req_tdata[WORD_W*(i+3) +: WORD_W];
   end

   pgi_front u_front (
      .clock         (clock),
      .en            (en),
      .pos_a         (pos_a),
      .pos_b         (pos_b),
      .mass_a        (req_tdata[223:192]),
      .mass_b        (req_tdata[255:224]),
      .g_constant    (g_ff),
      .time_step     (dt_ff),
      .min_r_squared (minr2_ff),
      .front         (front)
   );

   // Impulse magnitude G*mA*mB*dt / R2, one quotient bit per stage.
   pgi_udiv #(.QW(JMAG_W), .DW(R2_W)) u_jdiv (
      .clock  (clock),
      .en     (en),
      .num_hi (front.num_hi),
      .num_lo (front.num_lo),
      .den    (front.den),
      .quo    (quo1)
   );

   // Distance from the unfloored r2, in parallel with the divider.
   pgi_isqrt #(.RW(ROOT_W)) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (front.r2),
      .root  (root_early)
   );

   pgi_delay #(.W(ROOT_W), .D(JMAG_W - ROOT_W)) u_root_dly (
      .clock (clock),
      .en    (en),
      .din   (root_early),
      .dout  (root)
   );

   pgi_delay #(.W($bits(axis_type)*3 + 1), .D(JMAG_W)) u_side_dly (
      .clock (clock),
      .en    (en),
      .din   ({front.axis, front.ovf}),
      .dout  ({axis_d, ovf_d})
   );

   // A magnitude of 2^65 or more saturates every nonzero component, so clamp it.
   assign jmag = ovf_d ? '1 : quo1;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      pgi_axis u_axis (
         .clock   (clock),
         .en      (en),
         .jmag    (jmag),
         .root    (root),
         .axis    (axis_d[i]),
         .impulse (imp[i]),
         .sat     (sat[i])
      );
   end

   // Output register: holds the result while the far side stalls.
   always_ff @(posedge clock) begin
      if (en) begin
         tdata_ff <= {imp[2], imp[1], imp[0]};
         tuser_ff <= |sat;
      end
   end

   assign rsp_tvalid   = vld_ff[PIPE_LAT-1];
   assign rsp_tdata    = tdata_ff;
   assign rsp_tuser[0] = tuser_ff;
endmodule
`default_nettype wire

// ===== design/pgi_checker.sv =====
// Port-level checks for the pairwise gravity impulse block, bound to the top level.
// Depends on pairwise_gravity_impulse.
`default_nettype none
module pgi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output state");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF) || (rsp_tdata[31:0] == 32'h8000_0000) ||
         (rsp_tdata[63:32] == 32'h7FFF_FFFF) || (rsp_tdata[63:32] == 32'h8000_0000) ||
         (rsp_tdata[95:64] == 32'h7FFF_FFFF) || (rsp_tdata[95:64] == 32'h8000_0000))
      else $error("saturation flag without a clipped component");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind pairwise_gravity_impulse pgi_checker u_pgi_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for pairwise_gravity_impulse: directed body pairs, then random traffic.
// A local fixed-point predictor supplies the expected impulse for each input transfer.
// Depends on pgi_pkg and the pairwise_gravity_impulse top level.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import pgi_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_WAIT  = PIPE_LAT + 16;
   localparam logic [1:0]  CSR_SPARE   = 2'd3;   // unmapped register slot

   typedef struct packed {
      logic        saturated;
      logic [31:0] impulse_z;
      logic [31:0] impulse_y;
      logic [31:0] impulse_x;
   } impulse_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   // register copies used by the predictor
   logic [31:0] g_constant    = 32'd16777216;
   logic [31:0] time_step     = 32'd655;
   logic [31:0] min_r_squared = 32'd42950;

   impulse_type pending_impulses[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   pairwise_gravity_impulse DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Impulse on body A, worked out with exact wide integers.
   function automatic impulse_type gravity_impulse(input logic [255:0] pair);
      impulse_type res;
      logic [127:0] sep[3];
      logic         neg[3];
      logic [127:0] r2, floored, num, jmag, root, cand, quot, rem, mag, lim;
      longint       d;
      logic [31:0]  out_axis[3];
      res = '0;
      r2  = '0;
      for (int i = 0; i < 3; i++) begin
         d = longint'($signed(pair[32*(i+3) +: 32])) - longint'($signed(pair[32*i +: 32]));
         neg[i] = d < 0;
         sep[i] = neg[i] ? 128'(-d) : 128'(d);
         r2 += sep[i] * sep[i];
         out_axis[i] = '0;
      end
      // coincident bodies: no direction, no impulse
      if (r2 == 0) return res;
      floored = (r2 < 128'(min_r_squared)) ? 128'(min_r_squared) : r2;
      num  = (128'(pair[223:192]) * 128'(pair[255:224]))
           * (128'(g_constant) * 128'(time_step));
      jmag = num / (floored << 24);
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= r2) root = cand;
      end
      quot = jmag / root;
      rem  = jmag % root;
      for (int i = 0; i < 3; i++) begin
         if (sep[i] != 0) begin
            lim = neg[i] ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (quot > 128'hFFFF_FFFF) begin
               mag = lim;
               res.saturated = 1'b1;
            end else begin
               mag = quot * sep[i] + (rem * sep[i]) / root;
               if (mag > lim) begin
                  mag = lim;
                  res.saturated = 1'b1;
               end
            end
            out_axis[i] = neg[i] ? 32'(-mag) : mag[31:0];
         end
      end
      res.impulse_x = out_axis[0];
      res.impulse_y = out_axis[1];
      res.impulse_z = out_axis[2];
      return res;
   endfunction

   // Idle each cycle at the current rate, then hold the pair until accepted and log it.
   task automatic send_pair(input logic [255:0] pair);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      do @(posedge clock); while (!req_tready);
      pending_impulses.push_back(gravity_impulse(pair));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_impulses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write all three registers back to back, plus one write to the spare slot.
   task automatic load_registers(input logic [31:0] g, input logic [31:0] dt,
                                 input logic [31:0] floor_r2);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_G_CONSTANT;
      csr_wdata <= g;
      @(posedge clock);
      csr_index <= CSR_TIME_STEP;
      csr_wdata <= dt;
      @(posedge clock);
      csr_index <= CSR_MIN_R_SQUARED;
      csr_wdata <= floor_r2;
      @(posedge clock);
      // the unmapped slot must leave everything alone
      csr_index <= CSR_SPARE;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      g_constant    = g;
      time_step     = dt;
      min_r_squared = floor_r2;
   endtask

   function automatic logic [255:0] make_pair(input logic [31:0] ax, input logic [31:0] ay,
                                              input logic [31:0] az, input logic [31:0] bx,
                                              input logic [31:0] by, input logic [31:0] bz,
                                              input logic [31:0] ma, input logic [31:0] mb);
      return {mb, ma, bz, by, bx, az, ay, ax};
   endfunction

   function automatic logic [31:0] random_mass();
      if ($urandom_range(15) == 0) return 32'hFFFF_FFFF;
      return $urandom >> $urandom_range(31, 0);
   endfunction

   // Mostly nearby bodies so the impulse stays in range, with wide and degenerate pairs too.
   function automatic logic [255:0] random_pair();
      logic [31:0] a[3], b[3];
      int unsigned mode;
      mode = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         a[i] = $urandom;
         if (mode < 60)      b[i] = a[i] + (($urandom >> $urandom_range(31, 8)) ^
                                    ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0));
         else if (mode < 80) b[i] = $urandom;
         else if (mode < 88) b[i] = a[i];
         else                b[i] = (i == 0) ? a[i] + $urandom_range(1, 65536) : a[i];
      end
      return make_pair(a[0], a[1], a[2], b[0], b[1], b[2], random_mass(), random_mass());
   endfunction

   task automatic test_directed_cases();
      // coincident bodies
      send_pair(make_pair(32'd5, 32'd6, 32'd7, 32'd5, 32'd6, 32'd7, 32'hFFFF_FFFF, 32'h10000));
      // opposite corners of the range, positive and negative separations
      send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h10000, 32'h10000));
      // one unit apart on each axis in turn; heavy masses clip on the first two
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'h10000, 32'd0, 32'd0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h10000,
                          32'h10000, 32'h10000));
      // separation far below the floor
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF,
                          32'h10000, 32'h10000));
      // zero masses, then the same separation with nonzero masses
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'h30000, 32'h40000, 32'd0, 32'd0, 32'd0));
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'h30000, 32'h40000, 32'd0,
                          32'h20000, 32'h30000));
      // zero floor with the smallest separation
      load_registers(32'd16777216, 32'd655, 32'd0);
      send_pair(make_pair(32'd9, 32'd9, 32'd9, 32'd10, 32'd9, 32'd9, 32'h10000, 32'h10000));
      send_pair(make_pair(32'd9, 32'd9, 32'd9, 32'd8, 32'd10, 32'd9, 32'd1, 32'd1));
      // every register at its top value
      load_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1));
      send_pair(make_pair(32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // every register at zero
      load_registers(32'd0, 32'd0, 32'd0);
      send_pair(make_pair(32'd0, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   task automatic test_random_traffic(input int unsigned n, input int unsigned idle,
                                      input int unsigned stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) send_pair(random_pair());
   endtask

   // Drop rsp_tready at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // Compare each result transfer with the oldest pending impulse.
   always @(posedge clock) begin
      impulse_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_impulses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h sat %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_impulses.pop_front();
            if (rsp_tdata[31:0] !== want.impulse_x || rsp_tdata[63:32] !== want.impulse_y ||
                rsp_tdata[95:64] !== want.impulse_z || rsp_tuser[0] !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x %h y %h z %h sat %b, got x %h y %h z %h sat %b",
                           want.impulse_x, want.impulse_y, want.impulse_z, want.saturated,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0]);
            end
         end
      end
   end

   // Watchdog: advance the cycle count and abandon a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      load_registers(32'd16777216, 32'd655, 32'd42950);
      test_random_traffic(260, 0, 0);
      load_registers($urandom, $urandom, $urandom);
      test_random_traffic(260, 48, 0);
      load_registers(32'd1 << $urandom_range(31, 16), $urandom_range(65535), 32'd0);
      test_random_traffic(260, 0, 48);
      load_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_random_traffic(260, 22, 22);
      load_registers($urandom >> 8, $urandom >> 16, $urandom >> 12);
      test_random_traffic(260, 22, 22);
      wait_idle();
      if (mismatches == 0 && pending_impulses.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== pairwise_gravity_impulse.f =====
design/pgi_pkg.sv
design/pgi_delay.sv
design/pgi_udiv.sv
design/pgi_isqrt.sv
design/pgi_front.sv
design/pgi_axis.sv
design/pairwise_gravity_impulse.sv
design/pgi_checker.sv
bench/tb.sv
